### design/tdpel_pkg.sv
package tdpel_pkg;

  localparam int unsigned MAX_SIZE = 128;
  localparam int unsigned POS_W    = $clog2(MAX_SIZE);
  localparam int unsigned IDX_W    = $clog2(MAX_SIZE + 1);
  localparam int unsigned SIZE_W   = 8;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_FIX     = 2'd1,
    ST_CORRUPT = 2'd2
  } status_e;

  // Odd-line counts only need to tell none, one and more than one apart.
  typedef enum logic [1:0] {
    CNT_NONE = 2'd0,
    CNT_ONE  = 2'd1,
    CNT_MANY = 2'd2
  } odd_cnt_e;

  // Control shared by every cell of the column parity chain.
  typedef struct packed {
    logic shift;
    logic clear;
  } chain_ctrl_t;

  function automatic odd_cnt_e cnt_bump(odd_cnt_e cnt, logic odd);
    odd_cnt_e res;
    res = cnt;
    if (odd) begin
      res = (cnt == CNT_NONE) ? CNT_ONE : CNT_MANY;
    end
    return res;
  endfunction

endpackage

### design/tdpel_cell.sv
module tdpel_cell
  import tdpel_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  chain_ctrl_t ctrl_i,
  input  logic        d_i,
  output logic        q_o
);

  logic par_q;
  logic par_d;

  always_comb begin
    par_d = par_q;
    if (ctrl_i.clear) begin
      par_d = 1'b0;
    end else if (ctrl_i.shift) begin
      par_d = d_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q <= 1'b0;
    end else begin
      par_q <= par_d;
    end
  end

  assign q_o = par_q;

endmodule

### design/tdpel_col_chain.sv
module tdpel_col_chain
  import tdpel_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  chain_ctrl_t      ctrl_i,
  input  logic             head_i,
  input  logic [POS_W-1:0] tap_i,
  output logic             tap_o
);

  logic [MAX_SIZE-1:0] par;

  // Each item moves every column parity one cell along, so the parity of the
  // column about to be updated sits n-1 cells from the head.
  for (genvar i = 0; i < MAX_SIZE; i++) begin : g_cell
    logic d;
    if (i == 0) begin : g_head
      assign d = head_i;
    end else begin : g_body
      assign d = par[i-1];
    end
    tdpel_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl_i),
      .d_i    (d),
      .q_o    (par[i])
    );
  end

  assign tap_o = par[tap_i];

endmodule

### design/two_d_parity_error_locator.sv
// Two-dimensional parity checker: takes one matrix bit per item in row-major
// order, one item per cycle while in_ready_o is high, and gives one result
// item on the last bit of each n x n matrix (n from matrix_size, 0 acts as
// 1, above 128 acts as 128), with the result registered. Column parities
// circulate through a chain of 128 one-bit cells that advances with every
// item. A result waiting at the output does not hold up input unless a
// second result would overwrite it. Writing matrix_size discards the matrix
// in progress.
module two_d_parity_error_locator
  import tdpel_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                matrix_size_we_i,
  input  logic [SIZE_W-1:0]   matrix_size_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                cell_bit_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [IDX_W-1:0]    error_row_o,
  output logic [IDX_W-1:0]    error_col_o
);

  logic [POS_W-1:0] last_q, last_d;
  logic [POS_W-1:0] row_q, row_d;
  logic [POS_W-1:0] col_q, col_d;
  logic             row_par_q, row_par_d;
  odd_cnt_e         row_cnt_q, row_cnt_d;
  odd_cnt_e         col_cnt_q, col_cnt_d;
  logic [IDX_W-1:0] row_x_q, row_x_d;
  logic [IDX_W-1:0] col_x_q, col_x_d;

  logic                out_valid_q, out_valid_d;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [IDX_W-1:0]    err_row_q, err_row_d;
  logic [IDX_W-1:0]    err_col_q, err_col_d;

  logic        accept, last_col, last_row, done;
  logic        tap, col_par_new, row_par_new, col_odd, row_odd;
  odd_cnt_e    row_cnt_new, col_cnt_new;
  logic [IDX_W-1:0] row_x_new, col_x_new;
  chain_ctrl_t chain_ctrl;

  // Only the last bit of a matrix produces a result, so only that bit has to
  // wait for room in the output register.
  assign in_ready_o = !out_valid_q || out_ready_i || !done;
  assign accept     = in_valid_i && in_ready_o;

  assign last_col = (col_q == last_q);
  assign last_row = (row_q == last_q);
  assign done     = last_col && last_row;

  assign col_par_new = tap ^ cell_bit_i;
  assign row_par_new = row_par_q ^ cell_bit_i;
  assign col_odd     = last_row && col_par_new;
  assign row_odd     = last_col && row_par_new;

  assign row_cnt_new = cnt_bump(row_cnt_q, row_odd);
  assign col_cnt_new = cnt_bump(col_cnt_q, col_odd);
  assign row_x_new   = row_odd ? (row_x_q ^ ({1'b0, row_q} + IDX_W'(1))) : row_x_q;
  assign col_x_new   = col_odd ? (col_x_q ^ ({1'b0, col_q} + IDX_W'(1))) : col_x_q;

  assign chain_ctrl.shift = accept;
  assign chain_ctrl.clear = matrix_size_we_i || (accept && done);

  tdpel_col_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (chain_ctrl),
    .head_i (col_par_new),
    .tap_i  (last_q),
    .tap_o  (tap)
  );

  always_comb begin
    last_d    = last_q;
    row_d     = row_q;
    col_d     = col_q;
    row_par_d = row_par_q;
    row_cnt_d = row_cnt_q;
    col_cnt_d = col_cnt_q;
    row_x_d   = row_x_q;
    col_x_d   = col_x_q;

    if (matrix_size_we_i) begin
      if (matrix_size_i == '0) begin
        last_d = '0;
      end else if (matrix_size_i > SIZE_W'(MAX_SIZE)) begin
        last_d = POS_W'(MAX_SIZE - 1);
      end else begin
        last_d = POS_W'(matrix_size_i - SIZE_W'(1));
      end
      row_d     = '0;
      col_d     = '0;
      row_par_d = 1'b0;
      row_cnt_d = CNT_NONE;
      col_cnt_d = CNT_NONE;
      row_x_d   = '0;
      col_x_d   = '0;
    end else if (accept) begin
      if (done) begin
        row_d     = '0;
        col_d     = '0;
        row_par_d = 1'b0;
        row_cnt_d = CNT_NONE;
        col_cnt_d = CNT_NONE;
        row_x_d   = '0;
        col_x_d   = '0;
      end else begin
        row_cnt_d = row_cnt_new;
        col_cnt_d = col_cnt_new;
        row_x_d   = row_x_new;
        col_x_d   = col_x_new;
        if (last_col) begin
          col_d     = '0;
          row_d     = row_q + POS_W'(1);
          row_par_d = 1'b0;
        end else begin
          col_d     = col_q + POS_W'(1);
          row_par_d = row_par_new;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    status_d    = status_q;
    err_row_d   = err_row_q;
    err_col_d   = err_col_q;
    if (accept && done) begin
      out_valid_d = 1'b1;
      err_row_d   = '0;
      err_col_d   = '0;
      if (row_cnt_new == CNT_NONE && col_cnt_new == CNT_NONE) begin
        status_d = ST_OK;
      end else if (row_cnt_new == CNT_ONE && col_cnt_new == CNT_ONE) begin
        status_d  = ST_FIX;
        err_row_d = row_x_new;
        err_col_d = col_x_new;
      end else begin
        status_d = ST_CORRUPT;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q      <= POS_W'(3);
      row_q       <= '0;
      col_q       <= '0;
      row_par_q   <= 1'b0;
      row_cnt_q   <= CNT_NONE;
      col_cnt_q   <= CNT_NONE;
      row_x_q     <= '0;
      col_x_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      last_q      <= last_d;
      row_q       <= row_d;
      col_q       <= col_d;
      row_par_q   <= row_par_d;
      row_cnt_q   <= row_cnt_d;
      col_cnt_q   <= col_cnt_d;
      row_x_q     <= row_x_d;
      col_x_q     <= col_x_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q  <= status_d;
    err_row_q <= err_row_d;
    err_col_q <= err_col_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign error_row_o = err_row_q;
  assign error_col_o = err_col_q;

endmodule

### dv/parity_locator_checker.sv
module parity_locator_checker
  import tdpel_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                size_we_i,
  input  logic [SIZE_W-1:0]   size_i,
  input  logic                in_valid_i,
  input  logic                in_ready_i,
  input  logic                cell_bit_i,
  input  logic                out_valid_i,
  input  logic                out_ready_i,
  input  logic [STATUS_W-1:0] status_i,
  input  logic [IDX_W-1:0]    error_row_i,
  input  logic [IDX_W-1:0]    error_col_i,
  output int unsigned         fail_count_o,
  output int unsigned         results_pending_o,
  output int unsigned         ok_seen_o,
  output int unsigned         fix_seen_o,
  output int unsigned         corrupt_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [SIZE_W-1:0] SIZE_AT_RESET = SIZE_W'(4);
  localparam int unsigned       PRINT_LIMIT   = 30;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
  } verdict_t;

  verdict_t verdicts_due[$];

  // Shadow of the block's matrix state.
  logic [SIZE_W-1:0]   side_reg;
  int unsigned         row_at;
  int unsigned         col_at;
  logic                row_par;
  logic [MAX_SIZE-1:0] col_par;
  int unsigned         odd_rows;
  int unsigned         odd_cols;
  logic [IDX_W-1:0]    odd_row_sel;
  logic [IDX_W-1:0]    odd_col_sel;

  function automatic int unsigned side_in_use();
    if (side_reg == '0) return 1;
    if (side_reg > MAX_SIZE) return MAX_SIZE;
    return side_reg;
  endfunction

  task automatic clear_matrix_state();
    row_at      = 0;
    col_at      = 0;
    row_par     = 1'b0;
    col_par     = '0;
    odd_rows    = 0;
    odd_cols    = 0;
    odd_row_sel = '0;
    odd_col_sel = '0;
  endtask

  task automatic report_mismatch(input string msg);
    if (fail_count_o < PRINT_LIMIT) begin
      $display("[%0t] MISMATCH: %s", $realtime, msg);
    end
    fail_count_o += 1;
  endtask

  // Folds one cell into the parities and queues a verdict on the last cell.
  task automatic absorb_cell(input logic b);
    int unsigned n;
    verdict_t    v;
    n = side_in_use();
    row_par ^= b;
    col_par[col_at] ^= b;
    // Column parities are final while the last row streams in.
    if (row_at == n - 1 && col_par[col_at]) begin
      odd_cols += 1;
      odd_col_sel ^= IDX_W'(col_at + 1);
    end
    col_at += 1;
    if (col_at < n) return;
    if (row_par) begin
      odd_rows += 1;
      odd_row_sel ^= IDX_W'(row_at + 1);
    end
    row_par = 1'b0;
    col_at  = 0;
    row_at += 1;
    if (row_at < n) return;
    v.row = '0;
    v.col = '0;
    if (odd_rows == 0 && odd_cols == 0) begin
      v.status = ST_OK;
    end else if (odd_rows == 1 && odd_cols == 1) begin
      v.status = ST_FIX;
      v.row    = odd_row_sel;
      v.col    = odd_col_sel;
    end else begin
      v.status = ST_CORRUPT;
    end
    verdicts_due.push_back(v);
    clear_matrix_state();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    verdict_t due;
    if (!rst_ni) begin
      side_reg = SIZE_AT_RESET;
      clear_matrix_state();
      verdicts_due.delete();
      fail_count_o   = 0;
      ok_seen_o      = 0;
      fix_seen_o     = 0;
      corrupt_seen_o = 0;
    end else begin
      // A result out at this edge belongs to a matrix finished earlier.
      if (out_valid_i && out_ready_i) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch($sformatf("result item (status %0d) with none expected",
                                    status_i));
        end else begin
          due = verdicts_due.pop_front();
          if (status_i !== due.status) begin
            report_mismatch($sformatf("status: expected %0d, got %0d",
                                      due.status, status_i));
          end
          if (error_row_i !== due.row) begin
            report_mismatch($sformatf("error_row: expected %0d, got %0d",
                                      due.row, error_row_i));
          end
          if (error_col_i !== due.col) begin
            report_mismatch($sformatf("error_col: expected %0d, got %0d",
                                      due.col, error_col_i));
          end
          case (due.status)
            ST_OK:   ok_seen_o += 1;
            ST_FIX:  fix_seen_o += 1;
            default: corrupt_seen_o += 1;
          endcase
        end
      end
      if (size_we_i) begin
        side_reg = size_i;
        clear_matrix_state();
      end
      if (in_valid_i && in_ready_i) begin
        absorb_cell(cell_bit_i);
      end
    end
    results_pending_o = verdicts_due.size();
  end

endmodule

### dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tdpel_pkg::*;

  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned RANDOM_CELLS  = 660;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                matrix_size_we_i = 1'b0;
  logic [SIZE_W-1:0]   matrix_size_i    = '0;
  logic                in_valid_i       = 1'b0;
  logic                cell_bit_i       = 1'b0;
  logic                out_ready_i      = 1'b0;
  logic                in_ready_o;
  logic                out_valid_o;
  logic [STATUS_W-1:0] status_o;
  logic [IDX_W-1:0]    error_row_o;
  logic [IDX_W-1:0]    error_col_o;

  int unsigned fail_count;
  int unsigned results_pending;
  int unsigned ok_seen;
  int unsigned fix_seen;
  int unsigned corrupt_seen;

  int unsigned send_idle_max = 7;
  int unsigned recv_idle_max = 7;
  int unsigned quiet_cycles  = 0;
  int unsigned cells_sent    = 0;
  int          side_now      = 4;
  bit          grid [MAX_SIZE][MAX_SIZE];

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  two_d_parity_error_locator uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .matrix_size_we_i (matrix_size_we_i),
    .matrix_size_i    (matrix_size_i),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .cell_bit_i       (cell_bit_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .error_row_o      (error_row_o),
    .error_col_o      (error_col_o)
  );

  parity_locator_checker u_check (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .size_we_i         (matrix_size_we_i),
    .size_i            (matrix_size_i),
    .in_valid_i        (in_valid_i),
    .in_ready_i        (in_ready_o),
    .cell_bit_i        (cell_bit_i),
    .out_valid_i       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_i          (status_o),
    .error_row_i       (error_row_o),
    .error_col_i       (error_col_o),
    .fail_count_o      (fail_count),
    .results_pending_o (results_pending),
    .ok_seen_o         (ok_seen),
    .fix_seen_o        (fix_seen),
    .corrupt_seen_o    (corrupt_seen)
  );

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("Timeout: no item moved for %0d cycles", STALL_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side: a random hold before each item, then ready until it is taken.
  initial begin
    int unsigned hold;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      hold = $urandom_range(recv_idle_max, 0);
      if (hold > 0) begin
        out_ready_i <= 1'b0;
        repeat (hold) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  // Called at a falling edge; returns at the falling edge after the item is taken.
  task automatic send_cell(input logic b);
    int unsigned gap;
    gap = $urandom_range(send_idle_max, 0);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cell_bit_i <= b;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    cells_sent += 1;
  endtask

  // The size register is only written once all results are out.
  task automatic resize(input logic [SIZE_W-1:0] v);
    in_valid_i <= 1'b0;
    while (results_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    matrix_size_we_i <= 1'b1;
    matrix_size_i    <= v;
    @(negedge clk_i);
    matrix_size_we_i <= 1'b0;
    side_now = (v == '0) ? 1 : (v > MAX_SIZE) ? MAX_SIZE : int'(v);
  endtask

  // A negative flip count sends a fully random matrix. Otherwise every row and
  // column is made even first and then the given number of bits is flipped,
  // the first one at (fix_r, fix_c) when that is given.
  task automatic send_matrix(input int n, input int flips,
                             input int fix_r = -1, input int fix_c = -1);
    bit acc;
    int fr;
    int fc;
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        grid[r][c] = 1'($urandom_range(1, 0));
      end
    end
    if (flips >= 0) begin
      for (int r = 0; r < n - 1; r++) begin
        acc = 1'b0;
        for (int c = 0; c < n - 1; c++) acc ^= grid[r][c];
        grid[r][n-1] = acc;
      end
      for (int c = 0; c < n; c++) begin
        acc = 1'b0;
        for (int r = 0; r < n - 1; r++) acc ^= grid[r][c];
        grid[n-1][c] = acc;
      end
      for (int k = 0; k < flips; k++) begin
        if (k == 0 && fix_r >= 0) begin
          fr = fix_r;
          fc = fix_c;
        end else begin
          fr = $urandom_range(n - 1, 0);
          fc = $urandom_range(n - 1, 0);
        end
        grid[fr][fc] ^= 1'b1;
      end
    end
    for (int r = 0; r < n; r++) begin
      for (int c = 0; c < n; c++) begin
        send_cell(grid[r][c]);
      end
    end
  endtask

  task automatic send_junk(input int count);
    for (int i = 0; i < count; i++) begin
      send_cell(1'($urandom_range(1, 0)));
    end
  endtask

  function automatic int unsigned pick_idle();
    case ($urandom_range(3, 0))
      0:       return 0;
      1:       return 3;
      default: return 7;
    endcase
  endfunction

  initial begin
    int unsigned random_start;
    int          reps;
    int          side;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part, starting from the reset size of 4.
    send_matrix(side_now, 0);
    send_matrix(side_now, 1);
    send_matrix(side_now, 2);
    send_matrix(side_now, -1);
    resize(1);
    send_matrix(1, 0);
    send_matrix(1, 1);
    // A size of zero behaves as one.
    resize(0);
    send_matrix(1, 1);
    send_matrix(1, 0);
    resize(2);
    send_matrix(2, 1);
    send_matrix(2, 2);
    // Rewriting the size mid-matrix drops the bits taken so far.
    resize(3);
    send_junk(5);
    resize(3);
    send_matrix(3, 1);
    resize(255);
    send_junk(40);
    resize(5);
    send_matrix(5, 1);
    // The largest side and a size above it, each left as a partial matrix.
    resize(SIZE_W'(MAX_SIZE));
    send_junk(60);
    resize(200);
    send_junk(20);

    // Random part: mostly well-formed matrices, with or without planted errors.
    random_start = cells_sent;
    while (cells_sent - random_start < RANDOM_CELLS) begin
      side = ($urandom_range(9, 0) == 0) ? $urandom_range(16, 9) : $urandom_range(8, 0);
      resize(SIZE_W'(side));
      send_idle_max = pick_idle();
      recv_idle_max = pick_idle();
      reps = $urandom_range(4, 1);
      repeat (reps) begin
        case ($urandom_range(19, 0)) inside
          [0:7]:   send_matrix(side_now, 0);
          [8:13]:  send_matrix(side_now, 1);
          [14:16]: send_matrix(side_now, 2);
          default: send_matrix(side_now, -1);
        endcase
      end
      if ($urandom_range(7, 0) == 0) begin
        send_junk($urandom_range(side_now * side_now, 1));
      end
    end

    in_valid_i <= 1'b0;
    while (results_pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);

    $display("Checked %0d result items (%0d even, %0d single-bit, %0d corrupt) from %0d cells.",
             ok_seen + fix_seen + corrupt_seen, ok_seen, fix_seen, corrupt_seen, cells_sent);
    $display("Sides 0 to 16 plus sizes at and above the maximum, with mid-matrix resizes.");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
